FILE: rtl/multitouch_contact_tracker_top_assert.svh
// Assertion macros for the contact tracker.
// Used by multitouch_contact_tracker_top; needs clk and rst_n in scope.
`ifndef MULTITOUCH_CONTACT_TRACKER_TOP_ASSERT_SVH
`define MULTITOUCH_CONTACT_TRACKER_TOP_ASSERT_SVH

// condition holds in the same cycle
`define MCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define MCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mct_pkg.sv
// Shared types and constants of the contact tracker.
// No dependencies.
package mct_pkg;

    localparam int MAX_CONTACTS_DEF = 5;
    localparam int PADDR_W          = 5;
    localparam logic [7:0] FREE_ID  = 8'hFF;
    localparam logic [9:0] FULL_X   = 10'd1023;
    localparam logic [9:0] FULL_Y   = 10'd599;

    typedef enum logic [2:0] {
        REG_MIN_X    = 3'd0,
        REG_MAX_X    = 3'd1,
        REG_MIN_Y    = 3'd2,
        REG_MAX_Y    = 3'd3,
        REG_AXIS     = 3'd4,
        REG_RADIUS   = 3'd5,
        REG_DEBOUNCE = 3'd6
    } reg_idx_t;

    typedef enum logic {
        OP_POINT = 1'b0,
        OP_POLL  = 1'b1
    } op_t;

    typedef struct packed {
        logic [11:0] raw_min_x;
        logic [11:0] raw_max_x;
        logic [11:0] raw_min_y;
        logic [11:0] raw_max_y;
        logic [2:0]  axis_mode;
        logic [9:0]  match_radius;
        logic [15:0] release_debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic        active;
        logic        pressed;
        logic        released;
        logic        pending;
        logic        seen;
        logic [7:0]  id;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [9:0]  dx;
        logic [9:0]  dy;
        logic [31:0] since;
    } slot_t;

    localparam slot_t SLOT_RESET = '{active: 1'b0, pressed: 1'b0, released: 1'b0,
                                     pending: 1'b0, seen: 1'b0, id: FREE_ID,
                                     x: 10'd0, y: 10'd0, dx: 10'd0, dy: 10'd0,
                                     since: 32'd0};

    typedef struct packed {
        logic        matched;
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic [7:0]  id;
        logic [11:0] ry;
        logic [11:0] rx;
    } point_t;

    typedef struct packed {
        logic [3:0]  slot_index;
        logic        slot_active;
        logic        pressed_edge;
        logic        released_edge;
        logic [7:0]  contact_track_id;
        logic [9:0]  screen_x;
        logic [9:0]  screen_y;
        logic [9:0]  down_x;
        logic [9:0]  down_y;
        logic [31:0] press_count;
        logic        last_slot;
    } result_t;

endpackage

FILE: rtl/mct_if.sv
// Request and result channel interfaces of the contact tracker.
// No dependencies.
interface mct_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [7:0]  point_track_id;
    logic [31:0] now_ms;

    modport source (output valid, operation, raw_x, raw_y, point_track_id, now_ms,
                    input ready);
    modport sink (input valid, operation, raw_x, raw_y, point_track_id, now_ms,
                  output ready);
endinterface

interface mct_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  slot_index;
    logic        slot_active;
    logic        pressed_edge;
    logic        released_edge;
    logic [7:0]  contact_track_id;
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic [9:0]  down_x;
    logic [9:0]  down_y;
    logic [31:0] press_count;
    logic        last_slot;

    modport source (output valid, slot_index, slot_active, pressed_edge, released_edge,
                    contact_track_id, screen_x, screen_y, down_x, down_y,
                    press_count, last_slot,
                    input ready);
    modport sink (input valid, slot_index, slot_active, pressed_edge, released_edge,
                  contact_track_id, screen_x, screen_y, down_x, down_y,
                  press_count, last_slot,
                  output ready);
endinterface

FILE: rtl/mct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/mct_map.sv
// Raw to screen coordinate mapping: one multiply, then a bit-serial divider.
// Depends on mct_pkg.
module mct_map (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [11:0]   raw_x,
    input  logic [11:0]   raw_y,
    input  mct_pkg::cfg_t cfg,
    output logic          done,
    output logic [9:0]    screen_x,
    output logic [9:0]    screen_y
);
    localparam int QW = 23;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MUL  = 4'b0010,
        M_DIV  = 4'b0100,
        M_FIN  = 4'b1000
    } mstate_t;

    mstate_t        state_reg, state_next;
    logic           axis_reg, axis_next;
    logic [11:0]    rx_reg, rx_next, ry_reg, ry_next;
    logic [QW-1:0]  num_reg, num_next;
    logic [11:0]    den_reg, den_next;
    logic [11:0]    rem_reg, rem_next;
    logic           neg_reg, neg_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic [9:0]     sx_reg, sx_next, sy_reg, sy_next;
    logic           done_reg, done_next;

    logic [11:0]        raw_sel, lo, hi;
    logic [9:0]         full;
    logic               inv;
    logic signed [12:0] diff, span;
    logic signed [23:0] prod;
    logic [23:0]        pmag;
    logic [12:0]        smag;
    logic [12:0]        rem_sh;
    logic               qbit;
    logic signed [24:0] vs;
    logic signed [24:0] full_s;

    always_comb
    begin
        raw_sel = axis_reg ? (cfg.axis_mode[0] ? rx_reg : ry_reg)
                           : (cfg.axis_mode[0] ? ry_reg : rx_reg);
        lo      = axis_reg ? cfg.raw_min_y : cfg.raw_min_x;
        hi      = axis_reg ? cfg.raw_max_y : cfg.raw_max_x;
        full    = axis_reg ? mct_pkg::FULL_Y : mct_pkg::FULL_X;
        inv     = axis_reg ? cfg.axis_mode[2] : cfg.axis_mode[1];
        full_s  = 25'($signed({1'b0, full}));
        diff    = $signed({1'b0, raw_sel}) - $signed({1'b0, lo});
        span    = $signed({1'b0, hi}) - $signed({1'b0, lo});
        if (span == 13'sd0)
        begin
            span = 13'sd1;
        end
        prod    = 24'(diff) * 24'($signed({1'b0, full}));
        pmag    = prod[23] ? 24'(-prod) : 24'(prod);
        smag    = span[12] ? 13'(-span) : 13'(span);
        rem_sh  = {rem_reg, num_reg[QW-1]};
        qbit    = (rem_sh >= {1'b0, den_reg});
        vs      = neg_reg ? -$signed({2'b0, num_reg}) : $signed({2'b0, num_reg});
        if (inv)
        begin
            vs = full_s - vs;
        end
        if (vs < 0)
        begin
            vs = '0;
        end
        else if (vs > full_s)
        begin
            vs = full_s;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    rx_next    = raw_x;
                    ry_next    = raw_y;
                    axis_next  = 1'b0;
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                num_next   = pmag[QW-1:0];
                den_next   = smag[11:0];
                neg_next   = prod[23] ^ span[12];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = M_DIV;
            end
            M_DIV:
            begin
                rem_next = qbit ? 12'(rem_sh - {1'b0, den_reg}) : rem_sh[11:0];
                num_next = {num_reg[QW-2:0], qbit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QW - 1))
                begin
                    state_next = M_FIN;
                end
            end
            M_FIN:
            begin
                if (axis_reg)
                begin
                    sy_next    = vs[9:0];
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    sx_next    = vs[9:0];
                    axis_next  = 1'b1;
                    state_next = M_MUL;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg <= axis_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
    end

    assign done     = done_reg;
    assign screen_x = sx_reg;
    assign screen_y = sy_reg;
endmodule

FILE: rtl/mct_cfg.sv
// APB configuration registers of the contact tracker.
// Depends on mct_pkg.
module mct_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mct_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output mct_pkg::cfg_t                cfg
);
    mct_pkg::cfg_t     cfg_reg, cfg_next;
    mct_pkg::reg_idx_t idx;
    logic              wr;

    assign idx    = mct_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                mct_pkg::REG_MIN_X:    cfg_next.raw_min_x = pwdata[11:0];
                mct_pkg::REG_MAX_X:    cfg_next.raw_max_x = pwdata[11:0];
                mct_pkg::REG_MIN_Y:    cfg_next.raw_min_y = pwdata[11:0];
                mct_pkg::REG_MAX_Y:    cfg_next.raw_max_y = pwdata[11:0];
                mct_pkg::REG_AXIS:     cfg_next.axis_mode = pwdata[2:0];
                mct_pkg::REG_RADIUS:   cfg_next.match_radius = pwdata[9:0];
                mct_pkg::REG_DEBOUNCE: cfg_next.release_debounce_ms = pwdata[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            mct_pkg::REG_MIN_X:    prdata = {20'd0, cfg_reg.raw_min_x};
            mct_pkg::REG_MAX_X:    prdata = {20'd0, cfg_reg.raw_max_x};
            mct_pkg::REG_MIN_Y:    prdata = {20'd0, cfg_reg.raw_min_y};
            mct_pkg::REG_MAX_Y:    prdata = {20'd0, cfg_reg.raw_max_y};
            mct_pkg::REG_AXIS:     prdata = {29'd0, cfg_reg.axis_mode};
            mct_pkg::REG_RADIUS:   prdata = {22'd0, cfg_reg.match_radius};
            mct_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_reg.release_debounce_ms};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_min_x           <= 12'd0;
            cfg_reg.raw_max_x           <= 12'd1023;
            cfg_reg.raw_min_y           <= 12'd0;
            cfg_reg.raw_max_y           <= 12'd599;
            cfg_reg.axis_mode           <= 3'd0;
            cfg_reg.match_radius        <= 10'd40;
            cfg_reg.release_debounce_ms <= 16'd30;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

FILE: rtl/multitouch_contact_tracker_top.sv
// Top level of the multitouch contact tracker: poll sequencer over the slot and point RAMs.
// Depends on mct_pkg, mct_if, mct_ram, mct_map, mct_cfg and the assertion macro header.
//
//  channel   dir  handshake            payload
//  cmd       in   valid/ready          operation, raw_x, raw_y, point_track_id, now_ms
//  rsp       out  valid/ready          one slot result per slot per poll
//  apb       in   psel/penable/pready  seven config registers at 4*i
//
// A point request is written into the point RAM while it has room. A poll request retires
// the slots, maps the buffered points, matches them to live slots by id, runs a nearest
// search for every other point, then writes back each slot and delivers one result per slot.
// Slot state reads as its reset value through per-entry valid bits after reset. A stalled
// rsp holds the final walk; cmd is ready only while no poll is in progress.
`include "multitouch_contact_tracker_top_assert.svh"

module multitouch_contact_tracker_top #(
    parameter int MAX_CONTACTS = mct_pkg::MAX_CONTACTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mct_cmd_if.sink                      cmd,
    mct_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mct_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    localparam int SW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CW = $clog2(MAX_CONTACTS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_CONTACTS - 1);

    typedef enum logic [18:0] {
        ST_IDLE    = 19'h00001,
        ST_RET_RD  = 19'h00002,
        ST_RET_WR  = 19'h00004,
        ST_MAP_RD  = 19'h00008,
        ST_MAP_GO  = 19'h00010,
        ST_MAP_WT  = 19'h00020,
        ST_P1_PRD  = 19'h00040,
        ST_P1_PLT  = 19'h00080,
        ST_P1_SRD  = 19'h00100,
        ST_P1_CHK  = 19'h00200,
        ST_P2_PRD  = 19'h00400,
        ST_P2_PLT  = 19'h00800,
        ST_P2_SRD  = 19'h01000,
        ST_P2_SQ   = 19'h02000,
        ST_P2_CMP  = 19'h04000,
        ST_P2_ARD  = 19'h08000,
        ST_P2_AWR  = 19'h10000,
        ST_P3_RD   = 19'h20000,
        ST_P3_WR   = 19'h40000
    } st_t;

    mct_pkg::cfg_t cfg;

    st_t                  state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        r_reg, r_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [31:0]          now_reg, now_next;
    mct_pkg::point_t      pt_reg, pt_next;
    logic [20:0]          best_reg, best_next;
    logic [CW-1:0]        near_reg, near_next;
    logic                 nfound_reg, nfound_next;
    logic [CW-1:0]        free_reg, free_next;
    logic                 ffound_reg, ffound_next;
    logic [19:0]          sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic                 liveq_reg, liveq_next, freeq_reg, freeq_next;
    logic [31:0]          presses_reg, presses_next;
    mct_pkg::result_t     rsp_reg, rsp_next;
    logic                 rspv_reg, rspv_next;
    logic [MAX_CONTACTS-1:0] svalid_reg, svalid_next;
    logic                 svq_reg;

    logic                 slot_re, slot_we;
    logic [SW-1:0]        slot_raddr, slot_waddr;
    mct_pkg::slot_t       slot_wdata, slot_rdata, slot_q, s;
    logic                 pt_re, pt_we;
    logic [SW-1:0]        pt_raddr, pt_waddr;
    mct_pkg::point_t      pt_wdata, pt_q;

    logic                 map_start, map_done;
    logic [9:0]           map_sx, map_sy;

    logic                 live_q, last_pt, rsp_load;
    logic signed [21:0]   dxw, dyw, sqxw, sqyw;
    logic [20:0]          sq_sum;
    logic [31:0]          diff;

    mct_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mct_ram #(.WIDTH($bits(mct_pkg::slot_t)), .DEPTH(MAX_CONTACTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    mct_ram #(.WIDTH($bits(mct_pkg::point_t)), .DEPTH(MAX_CONTACTS)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_q)
    );

    mct_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (map_start),
        .raw_x    (pt_q.rx),
        .raw_y    (pt_q.ry),
        .cfg      (cfg),
        .done     (map_done),
        .screen_x (map_sx),
        .screen_y (map_sy)
    );

    assign slot_q    = svq_reg ? slot_rdata : mct_pkg::SLOT_RESET;
    assign live_q    = slot_q.active && !slot_q.seen;
    assign last_pt   = (CW'(r_reg + 1'b1) == n_reg);
    assign map_start = (state_reg == ST_MAP_GO);
    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        dxw    = 22'($signed({1'b0, slot_q.x}) - $signed({1'b0, pt_reg.sx}));
        dyw    = 22'($signed({1'b0, slot_q.y}) - $signed({1'b0, pt_reg.sy}));
        sqxw   = dxw * dxw;
        sqyw   = dyw * dyw;
        sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        diff   = now_reg - slot_q.since;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        r_next       = r_reg;
        i_next       = i_reg;
        now_next     = now_reg;
        pt_next      = pt_reg;
        best_next    = best_reg;
        near_next    = near_reg;
        nfound_next  = nfound_reg;
        free_next    = free_reg;
        ffound_next  = ffound_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        liveq_next   = liveq_reg;
        freeq_next   = freeq_reg;
        presses_next = presses_reg;
        rsp_next     = rsp_reg;
        rspv_next    = rspv_reg && !rsp.ready;
        svalid_next  = svalid_reg;
        slot_re      = 1'b0;
        slot_raddr   = i_reg[SW-1:0];
        slot_we      = 1'b0;
        slot_waddr   = i_reg[SW-1:0];
        slot_wdata   = slot_q;
        pt_re        = 1'b0;
        pt_raddr     = r_reg[SW-1:0];
        pt_we        = 1'b0;
        pt_waddr     = r_reg[SW-1:0];
        pt_wdata     = pt_reg;
        rsp_load     = 1'b0;
        s            = slot_q;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.operation == mct_pkg::OP_POINT)
                    begin
                        if (cnt_reg < CW'(MAX_CONTACTS))
                        begin
                            pt_we    = 1'b1;
                            pt_waddr = cnt_reg[SW-1:0];
                            pt_wdata = '{matched: 1'b0, sx: 10'd0, sy: 10'd0,
                                         id: cmd.point_track_id, ry: cmd.raw_y,
                                         rx: cmd.raw_x};
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        now_next   = cmd.now_ms;
                        n_next     = cnt_reg;
                        cnt_next   = '0;
                        i_next     = '0;
                        state_next = ST_RET_RD;
                    end
                end
            end
            ST_RET_RD:
            begin
                slot_re    = 1'b1;
                state_next = ST_RET_WR;
            end
            ST_RET_WR:
            begin
                s.pressed = 1'b0;
                if (slot_q.released)
                begin
                    s.released = 1'b0;
                    s.id       = mct_pkg::FREE_ID;
                end
                s.seen     = 1'b0;
                slot_we    = 1'b1;
                slot_wdata = s;
                if (i_reg == LAST_IDX)
                begin
                    i_next     = '0;
                    r_next     = '0;
                    state_next = (n_reg == '0) ? ST_P3_RD : ST_MAP_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RET_RD;
                end
            end
            ST_MAP_RD:
            begin
                pt_re      = 1'b1;
                state_next = ST_MAP_GO;
            end
            ST_MAP_GO:
            begin
                pt_next    = pt_q;
                state_next = ST_MAP_WT;
            end
            ST_MAP_WT:
            begin
                if (map_done)
                begin
                    pt_we    = 1'b1;
                    pt_wdata = '{matched: 1'b0, sx: map_sx, sy: map_sy, id: pt_reg.id,
                                 ry: pt_reg.ry, rx: pt_reg.rx};
                    if (last_pt)
                    begin
                        r_next     = '0;
                        state_next = ST_P1_PRD;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_MAP_RD;
                    end
                end
            end
            ST_P1_PRD:
            begin
                pt_re      = 1'b1;
                state_next = ST_P1_PLT;
            end
            ST_P1_PLT:
            begin
                pt_next    = pt_q;
                i_next     = '0;
                state_next = ST_P1_SRD;
            end
            ST_P1_SRD:
            begin
                slot_re    = 1'b1;
                state_next = ST_P1_CHK;
            end
            ST_P1_CHK:
            begin
                if (live_q && slot_q.id == pt_reg.id)
                begin
                    s.x        = pt_reg.sx;
                    s.y        = pt_reg.sy;
                    s.pending  = 1'b0;
                    s.seen     = 1'b1;
                    slot_we    = 1'b1;
                    slot_wdata = s;
                    pt_we      = 1'b1;
                    pt_wdata   = pt_reg;
                    pt_wdata.matched = 1'b1;
                end
                if ((live_q && slot_q.id == pt_reg.id) || i_reg == LAST_IDX)
                begin
                    if (last_pt)
                    begin
                        r_next     = '0;
                        state_next = ST_P2_PRD;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_P1_PRD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_P1_SRD;
                end
            end
            ST_P2_PRD:
            begin
                pt_re      = 1'b1;
                state_next = ST_P2_PLT;
            end
            ST_P2_PLT:
            begin
                pt_next     = pt_q;
                i_next      = '0;
                best_next   = 21'({11'd0, cfg.match_radius} * {11'd0, cfg.match_radius});
                nfound_next = 1'b0;
                ffound_next = 1'b0;
                if (pt_q.matched)
                begin
                    if (last_pt)
                    begin
                        i_next     = '0;
                        state_next = ST_P3_RD;
                    end
                    else
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = ST_P2_PRD;
                    end
                end
                else
                begin
                    state_next = ST_P2_SRD;
                end
            end
            ST_P2_SRD:
            begin
                slot_re    = 1'b1;
                state_next = ST_P2_SQ;
            end
            ST_P2_SQ:
            begin
                sqx_next   = sqxw[19:0];
                sqy_next   = sqyw[19:0];
                liveq_next = live_q;
                freeq_next = !slot_q.active;
                state_next = ST_P2_CMP;
            end
            ST_P2_CMP:
            begin
                if (liveq_reg && sq_sum <= best_reg)
                begin
                    best_next   = sq_sum;
                    near_next   = i_reg;
                    nfound_next = 1'b1;
                end
                if (freeq_reg && !ffound_reg)
                begin
                    free_next   = i_reg;
                    ffound_next = 1'b1;
                end
                if (i_reg == LAST_IDX)
                begin
                    state_next = ST_P2_ARD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_P2_SRD;
                end
            end
            ST_P2_ARD:
            begin
                if (nfound_reg || ffound_reg)
                begin
                    slot_re    = 1'b1;
                    slot_raddr = nfound_reg ? near_reg[SW-1:0] : free_reg[SW-1:0];
                    state_next = ST_P2_AWR;
                end
                else if (last_pt)
                begin
                    i_next     = '0;
                    state_next = ST_P3_RD;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_P2_PRD;
                end
            end
            ST_P2_AWR:
            begin
                s.id      = pt_reg.id;
                s.x       = pt_reg.sx;
                s.y       = pt_reg.sy;
                s.pending = 1'b0;
                s.seen    = 1'b1;
                if (!nfound_reg)
                begin
                    s.active     = 1'b1;
                    s.pressed    = 1'b1;
                    s.released   = 1'b0;
                    s.dx         = pt_reg.sx;
                    s.dy         = pt_reg.sy;
                    presses_next = presses_reg + 32'd1;
                end
                slot_we    = 1'b1;
                slot_waddr = nfound_reg ? near_reg[SW-1:0] : free_reg[SW-1:0];
                slot_wdata = s;
                if (last_pt)
                begin
                    i_next     = '0;
                    state_next = ST_P3_RD;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_P2_PRD;
                end
            end
            ST_P3_RD:
            begin
                if (!rspv_reg || rsp.ready)
                begin
                    slot_re    = 1'b1;
                    state_next = ST_P3_WR;
                end
            end
            ST_P3_WR:
            begin
                if (live_q)
                begin
                    if (!slot_q.pending)
                    begin
                        s.pending = 1'b1;
                        s.since   = now_reg;
                    end
                    else if (!diff[31] && diff >= {16'd0, cfg.release_debounce_ms})
                    begin
                        s.active   = 1'b0;
                        s.pending  = 1'b0;
                        s.released = 1'b1;
                    end
                end
                slot_we    = 1'b1;
                slot_wdata = s;
                rsp_load   = 1'b1;
                rspv_next  = 1'b1;
                rsp_next   = '{slot_index: 4'(i_reg), slot_active: s.active,
                               pressed_edge: s.pressed, released_edge: s.released,
                               contact_track_id: s.id, screen_x: s.x, screen_y: s.y,
                               down_x: s.dx, down_y: s.dy, press_count: presses_reg,
                               last_slot: (i_reg == LAST_IDX)};
                if (i_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_P3_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (slot_we)
        begin
            svalid_next[slot_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            presses_reg <= '0;
            rspv_reg    <= 1'b0;
            svalid_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            presses_reg <= presses_next;
            rspv_reg    <= rspv_next;
            svalid_reg  <= svalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        r_reg      <= r_next;
        i_reg      <= i_next;
        now_reg    <= now_next;
        pt_reg     <= pt_next;
        best_reg   <= best_next;
        near_reg   <= near_next;
        nfound_reg <= nfound_next;
        free_reg   <= free_next;
        ffound_reg <= ffound_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        liveq_reg  <= liveq_next;
        freeq_reg  <= freeq_next;
        rsp_reg    <= rsp_next;
        if (slot_re)
        begin
            svq_reg <= svalid_reg[slot_raddr];
        end
    end

    assign rsp.valid            = rspv_reg;
    assign rsp.slot_index       = rsp_reg.slot_index;
    assign rsp.slot_active      = rsp_reg.slot_active;
    assign rsp.pressed_edge     = rsp_reg.pressed_edge;
    assign rsp.released_edge    = rsp_reg.released_edge;
    assign rsp.contact_track_id = rsp_reg.contact_track_id;
    assign rsp.screen_x         = rsp_reg.screen_x;
    assign rsp.screen_y         = rsp_reg.screen_y;
    assign rsp.down_x           = rsp_reg.down_x;
    assign rsp.down_y           = rsp_reg.down_y;
    assign rsp.press_count      = rsp_reg.press_count;
    assign rsp.last_slot        = rsp_reg.last_slot;

    `MCT_ASSERT_IMP(a_slot_rw_sep, slot_we && slot_re, slot_waddr != slot_raddr, "slot RAM read and write collide")
    `MCT_ASSERT_IMP(a_rsp_load_empty, rsp_load, !rspv_reg, "result register overwritten")
    `MCT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CW'(MAX_CONTACTS), "point count overflow")
    `MCT_ASSERT_NXT(a_last_idle, rsp_load && rsp_next.last_slot, state_reg == ST_IDLE, "poll did not end after last slot")
endmodule
